### hw/rtl/mbh_pkg.sv
// Shared types and constants for the MurmurHash2 bucket hash block.
`default_nettype none
package mbh_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int HASH_W   = 32;
    localparam int BUCKET_W = 10;
    localparam int POS_W    = 2;

    // Packed stream widths (whole bytes)
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 48;

    // MurmurHash2 mixing constants
    localparam logic [HASH_W-1:0] MIX_M  = 32'h5bd1_e995;
    localparam int                MIX_R  = 24;
    localparam int                FIN_R1 = 13;
    localparam int                FIN_R2 = 15;

    // Bucket table size, a power of two
    localparam logic [HASH_W-1:0] TABLE_SIZE = 32'd1024;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_K1,
        ST_MUL_K2,
        ST_MUL_H,
        ST_TAIL,
        ST_AVAL,
        ST_EMIT
    } state_t;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_K1,
        OP_K2,
        OP_HMIX,
        OP_TAIL,
        OP_AVAL,
        OP_EMIT
    } op_t;

    // Controller to datapath
    typedef struct packed {
        op_t op;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic zero_len;   // incoming item opens an empty key
        logic word_full;  // incoming byte completes a 4-byte word
        logic out_busy;   // output register holds an untaken result
    } status_t;

endpackage
`default_nettype wire

### hw/rtl/mbh_ctrl.sv
// Sequencing state machine for the MurmurHash2 bucket hash block.
`default_nettype none
module mbh_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    input  wire logic             s_tlast,
    output logic                  s_tready,
    input  wire mbh_pkg::status_t status,
    output mbh_pkg::cmd_t         cmd
);

    mbh_pkg::state_t state_reg, state_next;
    logic            fin_reg, fin_next;
    logic            accept;

    assign accept = s_tvalid && (state_reg == mbh_pkg::ST_IDLE);

    // State and pending-finish registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mbh_pkg::ST_IDLE;
            fin_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        fin_next   = fin_reg;
        unique case (state_reg)
            mbh_pkg::ST_IDLE: begin
                if (accept) begin
                    fin_next = s_tlast;
                    if (status.zero_len) begin
                        state_next = mbh_pkg::ST_AVAL;
                    end else if (status.word_full) begin
                        state_next = mbh_pkg::ST_MUL_K1;
                    end else if (s_tlast) begin
                        state_next = mbh_pkg::ST_TAIL;
                    end
                end
            end
            mbh_pkg::ST_MUL_K1: state_next = mbh_pkg::ST_MUL_K2;
            mbh_pkg::ST_MUL_K2: state_next = mbh_pkg::ST_MUL_H;
            mbh_pkg::ST_MUL_H: begin
                state_next = fin_reg ? mbh_pkg::ST_AVAL : mbh_pkg::ST_IDLE;
            end
            mbh_pkg::ST_TAIL:   state_next = mbh_pkg::ST_AVAL;
            mbh_pkg::ST_AVAL:   state_next = mbh_pkg::ST_EMIT;
            mbh_pkg::ST_EMIT: begin
                if (!status.out_busy) begin
                    state_next = mbh_pkg::ST_IDLE;
                end
            end
            default: state_next = mbh_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_tready = 1'b0;
        cmd.op   = mbh_pkg::OP_NONE;
        unique case (state_reg)
            mbh_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    cmd.op = mbh_pkg::OP_LOAD;
                end
            end
            mbh_pkg::ST_MUL_K1: cmd.op = mbh_pkg::OP_K1;
            mbh_pkg::ST_MUL_K2: cmd.op = mbh_pkg::OP_K2;
            mbh_pkg::ST_MUL_H:  cmd.op = mbh_pkg::OP_HMIX;
            mbh_pkg::ST_TAIL:   cmd.op = mbh_pkg::OP_TAIL;
            mbh_pkg::ST_AVAL:   cmd.op = mbh_pkg::OP_AVAL;
            mbh_pkg::ST_EMIT: begin
                if (!status.out_busy) begin
                    cmd.op = mbh_pkg::OP_EMIT;
                end
            end
            default: cmd.op = mbh_pkg::OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

### hw/rtl/mbh_datapath.sv
// Byte packing, shared multiplier and result register for the hash block.
`default_nettype none
module mbh_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [mbh_pkg::S_DATA_W-1:0]    s_tdata,
    input  wire logic                            m_tready,
    output logic                                 m_tvalid,
    output logic [mbh_pkg::M_DATA_W-1:0]         m_tdata,
    input  wire mbh_pkg::cmd_t                   cmd,
    output mbh_pkg::status_t                     status
);

    logic [mbh_pkg::HASH_W-1:0]   hash_reg, hash_next;
    logic [mbh_pkg::HASH_W-1:0]   word_reg, word_next;
    logic [mbh_pkg::HASH_W-1:0]   k_reg, k_next;
    logic [mbh_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic                         in_key_reg, in_key_next;
    logic [mbh_pkg::HASH_W-1:0]   out_hash_reg, out_hash_next;
    logic [mbh_pkg::BUCKET_W-1:0] out_bucket_reg, out_bucket_next;
    logic                         out_valid_reg, out_valid_next;

    logic [mbh_pkg::BYTE_W-1:0]   in_byte;
    logic [mbh_pkg::LEN_W-1:0]    in_len;
    logic [mbh_pkg::POS_W-1:0]    eff_pos;
    logic [mbh_pkg::HASH_W-1:0]   eff_word;
    logic [mbh_pkg::HASH_W-1:0]   byte_shifted;
    logic [mbh_pkg::HASH_W-1:0]   mul_a;
    logic [mbh_pkg::HASH_W-1:0]   product;
    logic [mbh_pkg::HASH_W-1:0]   hash_fin;
    logic [mbh_pkg::HASH_W-1:0]   bucket_wide;

    assign in_byte = s_tdata[mbh_pkg::BYTE_W-1:0];
    assign in_len  = s_tdata[mbh_pkg::BYTE_W +: mbh_pkg::LEN_W];

    // A new key starts from an empty word
    assign eff_pos      = in_key_reg ? pos_reg : '0;
    assign eff_word     = in_key_reg ? word_reg : '0;
    assign byte_shifted = {{(mbh_pkg::HASH_W-mbh_pkg::BYTE_W){1'b0}}, in_byte}
                          << {eff_pos, 3'b000};

    assign status.zero_len  = !in_key_reg && (in_len == '0);
    assign status.word_full = (eff_pos == 2'd3);
    assign status.out_busy  = out_valid_reg && !m_tready;

    // Shared multiplier operand select; the other factor is always MIX_M
    always_comb begin
        case (cmd.op)
            mbh_pkg::OP_K1:   mul_a = word_reg;
            mbh_pkg::OP_K2:   mul_a = k_reg ^ (k_reg >> mbh_pkg::MIX_R);
            mbh_pkg::OP_HMIX: mul_a = hash_reg;
            mbh_pkg::OP_TAIL: mul_a = hash_reg ^ word_reg;
            mbh_pkg::OP_AVAL: mul_a = hash_reg ^ (hash_reg >> mbh_pkg::FIN_R1);
            default:          mul_a = hash_reg;
        endcase
    end

    assign product     = mul_a * mbh_pkg::MIX_M;
    assign hash_fin    = hash_reg ^ (hash_reg >> mbh_pkg::FIN_R2);
    assign bucket_wide = hash_fin % mbh_pkg::TABLE_SIZE;

    // Next-state values per operation
    always_comb begin
        hash_next       = hash_reg;
        word_next       = word_reg;
        k_next          = k_reg;
        pos_next        = pos_reg;
        in_key_next     = in_key_reg;
        out_hash_next   = out_hash_reg;
        out_bucket_next = out_bucket_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        case (cmd.op)
            mbh_pkg::OP_LOAD: begin
                if (!in_key_reg) begin
                    hash_next = {{(mbh_pkg::HASH_W-mbh_pkg::LEN_W){1'b0}}, in_len};
                end
                word_next   = eff_word | byte_shifted;
                pos_next    = eff_pos + 2'd1;
                in_key_next = 1'b1;
            end
            mbh_pkg::OP_K1: k_next = product;
            mbh_pkg::OP_K2: k_next = product;
            mbh_pkg::OP_HMIX: begin
                hash_next = product ^ k_reg;
                word_next = '0;
                pos_next  = '0;
            end
            mbh_pkg::OP_TAIL: hash_next = product;
            mbh_pkg::OP_AVAL: hash_next = product;
            mbh_pkg::OP_EMIT: begin
                out_hash_next   = hash_fin;
                out_bucket_next = bucket_wide[mbh_pkg::BUCKET_W-1:0];
                out_valid_next  = 1'b1;
                in_key_next     = 1'b0;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_key_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end else begin
            in_key_reg    <= in_key_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        hash_reg       <= hash_next;
        word_reg       <= word_next;
        k_reg          <= k_next;
        out_hash_reg   <= out_hash_next;
        out_bucket_reg <= out_bucket_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(mbh_pkg::M_DATA_W-mbh_pkg::HASH_W-mbh_pkg::BUCKET_W){1'b0}},
                       out_bucket_reg, out_hash_reg};

endmodule
`default_nettype wire

### hw/rtl/murmur2_bucket_hash.sv
// Top level: 32-bit MurmurHash2 (seed 0) over byte-serial keys, with bucket index.
// A byte that leaves its word open is only packed; one that completes it is mixed in by three
// passes through the one shared 32x32 multiplier. After the last byte is accepted, m_tvalid rises
// once the remaining steps are done (tail mix if 1-3 bytes pending, avalanche, emit), later while
// an earlier result is still untaken.
// A new byte is accepted only in the idle state, so input stalls while a word or result is in work.
// Reset (aresetn low, synchronous) empties the key state and the output register.
`default_nettype none
module murmur2_bucket_hash (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [mbh_pkg::S_DATA_W-1:0]  s_tdata,   // [7:0] byte_value, [23:8] string_length
    input  wire logic                          s_tlast,   // last_byte
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [mbh_pkg::M_DATA_W-1:0]       m_tdata    // [31:0] hash_value, [41:32] bucket_index
);

    mbh_pkg::cmd_t    cmd;
    mbh_pkg::status_t status;

    mbh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mbh_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule
`default_nettype wire

### hw/rtl/mbh_checker.sv
// Port-level checks for the MurmurHash2 bucket hash block, bound to the top level.
`default_nettype none
module mbh_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [mbh_pkg::M_DATA_W-1:0]  m_tdata
);

    // A result held back stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("m_tvalid dropped before the transaction completed");

    // A stalled result keeps its payload
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high right after reset");

    // Bucket index is the low bits of the hash for a power-of-two table
    a_bucket: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[41:32] == m_tdata[9:0]))
        else $error("bucket_index does not match hash_value");

    // The input side reopens as soon as a new result is issued
    a_ready_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("input not ready when a new result was issued");

endmodule

bind murmur2_bucket_hash mbh_checker u_mbh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
